FILE: rtl/tvsp_pkg.sv
`timescale 1ns / 1ps

package tvsp_pkg;

    localparam int unsigned MAX_FRAMES   = 16384;
    localparam int unsigned MAX_CHANNELS = 2;

    localparam int unsigned ADDR_W    = 15;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request action codes
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_PAUSE = 3'd4;
    localparam logic [2:0] ACT_SEEK  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MUSIC_GAIN    = 2'd0;
    localparam logic [1:0] REG_EFFECT_GAIN   = 2'd1;
    localparam logic [1:0] REG_EFFECT_REPEAT = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // one queued job for the mixing side: a memory load or a tick
    typedef struct packed {
        logic                     is_load;
        logic                     voice;
        logic [ADDR_W-1:0]        load_addr;
        logic [15:0]              load_value;
        logic                     two_ch;
        logic                     m_ok;
        logic                     e_ok;
        logic [ADDR_W-1:0]        m_base;
        logic [ADDR_W-1:0]        e_base;
        logic                     m_act;
        logic                     e_act;
    } t_job;

endpackage

FILE: rtl/tvsp_front.sv
`timescale 1ns / 1ps

module tvsp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_action,
    input  logic                 i_voice_select,
    input  logic [14:0]          i_sample_index,
    input  logic signed [15:0]   i_sample_value,
    input  logic [14:0]          i_clip_frames,
    input  logic                 i_pause_flag,
    input  logic [16:0]          i_seek_fraction,
    input  logic                 i_effect_repeat,
    input  logic [1:0]           i_channel_count,
    input  logic                 i_q_full,
    output logic                 o_push,
    output tvsp_pkg::t_job       o_job
);

    logic [14:0] r_pos [2];
    logic [14:0] n_pos [2];
    logic [14:0] r_len [2];
    logic [14:0] n_len [2];
    logic [1:0]  r_play, n_play;
    logic [1:0]  r_pause, n_pause;

    logic        w_acc;
    logic        w_two_ch;
    logic [1:0]  w_loop;
    logic [1:0]  w_go;
    logic [1:0]  w_wrap;
    logic [1:0]  w_ok;
    logic [14:0] w_pos_use [2];
    logic [14:0] w_base [2];
    logic [14:0] w_start_len;
    logic [14:0] w_sel_len;
    logic        w_sel_play;
    logic [16:0] w_frac;
    logic [31:0] w_seek_prod;
    logic [15:0] w_seek_pos;
    logic [14:0] w_seek_new;

    assign o_in_ready = !i_q_full;
    assign w_acc      = i_in_valid && !i_q_full;

    // zero acts as one channel, three as two
    assign w_two_ch = (i_channel_count[1]) && (tvsp_pkg::MAX_CHANNELS >= 2);
    assign w_loop   = {i_effect_repeat, 1'b1};

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            w_go[v]      = r_play[v] && !r_pause[v] && (r_len[v] != 15'd0);
            w_wrap[v]    = r_pos[v] >= r_len[v];
            w_ok[v]      = w_go[v] && !(w_wrap[v] && !w_loop[v]);
            w_pos_use[v] = w_wrap[v] ? 15'd0 : r_pos[v];
            w_base[v]    = w_two_ch ? {w_pos_use[v][13:0], 1'b0} : w_pos_use[v];
        end
    end

    assign w_start_len = (32'(i_clip_frames) > tvsp_pkg::MAX_FRAMES) ?
                         15'(tvsp_pkg::MAX_FRAMES) : i_clip_frames;

    assign w_sel_len   = i_voice_select ? r_len[1] : r_len[0];
    assign w_sel_play  = i_voice_select ? r_play[1] : r_play[0];
    assign w_frac      = (i_seek_fraction > 17'd65536) ? 17'd65536 : i_seek_fraction;
    assign w_seek_prod = 32'(w_frac) * 32'(w_sel_len);
    assign w_seek_pos  = w_seek_prod[31:16];
    assign w_seek_new  = (w_seek_pos >= 16'(w_sel_len)) ? (w_sel_len - 15'd1)
                                                         : w_seek_pos[14:0];

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_play  = r_play;
        n_pause = r_pause;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.voice      = i_voice_select;
        o_job.load_addr  = i_sample_index;
        o_job.load_value = i_sample_value;
        o_job.two_ch     = w_two_ch;
        o_job.m_base     = w_base[0];
        o_job.e_base     = w_base[1];
        o_job.m_ok       = w_ok[0];
        o_job.e_ok       = w_ok[1];
        if (w_acc) begin
            unique case (i_action)
                tvsp_pkg::ACT_TICK: begin
                    for (int v = 0; v < 2; v++) begin
                        if (w_go[v] && w_wrap[v] && !w_loop[v]) begin
                            n_play[v] = 1'b0;
                        end else if (w_go[v]) begin
                            n_pos[v] = w_pos_use[v] + 15'd1;
                        end
                    end
                    o_push = 1'b1;
                end
                tvsp_pkg::ACT_LOAD: begin
                    o_push        = 1'b1;
                    o_job.is_load = 1'b1;
                end
                tvsp_pkg::ACT_START: begin
                    for (int v = 0; v < 2; v++) begin
                        if (i_voice_select == v[0]) begin
                            n_len[v]   = w_start_len;
                            n_pos[v]   = 15'd0;
                            n_pause[v] = 1'b0;
                            n_play[v]  = (w_start_len != 15'd0);
                        end
                    end
                end
                tvsp_pkg::ACT_STOP: begin
                    for (int v = 0; v < 2; v++) begin
                        if (i_voice_select == v[0]) begin
                            n_len[v]   = 15'd0;
                            n_pos[v]   = 15'd0;
                            n_pause[v] = 1'b0;
                            n_play[v]  = 1'b0;
                        end
                    end
                end
                tvsp_pkg::ACT_PAUSE: begin
                    for (int v = 0; v < 2; v++) begin
                        if (i_voice_select == v[0]) begin
                            n_pause[v] = i_pause_flag;
                        end
                    end
                end
                tvsp_pkg::ACT_SEEK: begin
                    for (int v = 0; v < 2; v++) begin
                        if ((i_voice_select == v[0]) && w_sel_play && (w_sel_len != 15'd0)) begin
                            n_pos[v] = w_seek_new;
                        end
                    end
                end
                default: ;
            endcase
        end
        o_job.m_act = n_play[0];
        o_job.e_act = n_play[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_play   <= '0;
            r_pause  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_play  <= n_play;
            r_pause <= n_pause;
        end
    end

endmodule

FILE: rtl/tvsp_queue.sv
`timescale 1ns / 1ps

module tvsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tvsp_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    output tvsp_pkg::t_job  o_job,
    input  logic            i_pop
);

    tvsp_pkg::t_job                  r_mem [tvsp_pkg::QUEUE_DEPTH];
    logic [tvsp_pkg::QPTR_W-1:0]     r_wr;
    logic [tvsp_pkg::QPTR_W-1:0]     r_rd;
    logic [tvsp_pkg::QCNT_W-1:0]     r_cnt;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_cnt == tvsp_pkg::QCNT_W'(tvsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/tvsp_back.sv
`timescale 1ns / 1ps

module tvsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  tvsp_pkg::t_job      i_job,
    output logic                o_pop,
    input  logic [15:0]         i_music_gain,
    input  logic [15:0]         i_effect_gain,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_mixed_sample,
    output logic                o_channel_index,
    output logic                o_frame_last,
    output logic                o_music_active,
    output logic                o_effect_active
);

    typedef struct packed {
        logic ch;
        logic last;
        logic m_ok;
        logic e_ok;
        logic m_act;
        logic e_act;
    } t_meta;

    logic [15:0] r_music_mem  [tvsp_pkg::MEM_DEPTH];
    logic [15:0] r_effect_mem [tvsp_pkg::MEM_DEPTH];

    logic                      r_ch;
    logic                      r_s1_valid;
    t_meta                     r_s1;
    logic signed [15:0]        r_m_rd;
    logic signed [15:0]        r_e_rd;
    logic                      r_s2_valid;
    t_meta                     r_s2;
    logic signed [32:0]        r_m_prod;
    logic signed [32:0]        r_e_prod;
    logic                      r_out_valid;
    t_meta                     r_out;
    logic signed [15:0]        r_out_sample;

    logic                      w_en;
    logic                      w_issue;
    logic                      w_last;
    logic                      w_wr_music;
    logic                      w_wr_effect;
    logic [tvsp_pkg::ADDR_W-1:0] w_m_addr;
    logic [tvsp_pkg::ADDR_W-1:0] w_e_addr;
    t_meta                     w_meta;
    logic signed [32:0]        w_m_prod;
    logic signed [32:0]        w_e_prod;
    logic signed [32:0]        w_m_adj;
    logic signed [32:0]        w_e_adj;
    logic signed [18:0]        w_m_scl;
    logic signed [18:0]        w_e_scl;
    logic signed [15:0]        w_acc1;
    logic signed [15:0]        w_acc2;

    function automatic logic signed [15:0] f_sat16(input logic signed [19:0] v);
        logic signed [15:0] res;
        if (v > 20'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // whole pipe holds while a finished sample waits at the output
    assign w_en    = !r_out_valid || i_out_ready;
    assign w_issue = i_job_valid && w_en;
    assign w_last  = !i_job.two_ch || r_ch;
    assign o_pop   = w_issue && (i_job.is_load || w_last);

    assign w_wr_music  = w_issue && i_job.is_load && !i_job.voice;
    assign w_wr_effect = w_issue && i_job.is_load && i_job.voice;
    assign w_m_addr    = i_job.m_base + tvsp_pkg::ADDR_W'(r_ch);
    assign w_e_addr    = i_job.e_base + tvsp_pkg::ADDR_W'(r_ch);

    assign w_meta.ch    = r_ch;
    assign w_meta.last  = w_last;
    assign w_meta.m_ok  = i_job.m_ok;
    assign w_meta.e_ok  = i_job.e_ok;
    assign w_meta.m_act = i_job.m_act;
    assign w_meta.e_act = i_job.e_act;

    always_ff @(posedge i_clk) begin
        if (w_wr_music) begin
            r_music_mem[i_job.load_addr] <= i_job.load_value;
        end else if (w_issue) begin
            r_m_rd <= r_music_mem[w_m_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_effect) begin
            r_effect_mem[i_job.load_addr] <= i_job.load_value;
        end else if (w_issue) begin
            r_e_rd <= r_effect_mem[w_e_addr];
        end
    end

    assign w_m_prod = 33'($signed(r_m_rd)) * 33'($signed({1'b0, i_music_gain}));
    assign w_e_prod = 33'($signed(r_e_rd)) * 33'($signed({1'b0, i_effect_gain}));

    // divide by 16384 rounding toward zero
    assign w_m_adj = r_m_prod + (r_m_prod[32] ? 33'sd16383 : 33'sd0);
    assign w_e_adj = r_e_prod + (r_e_prod[32] ? 33'sd16383 : 33'sd0);
    assign w_m_scl = w_m_adj[32:14];
    assign w_e_scl = w_e_adj[32:14];

    assign w_acc1 = r_s2.m_ok ? f_sat16(20'(w_m_scl)) : 16'sd0;
    assign w_acc2 = r_s2.e_ok ? f_sat16(20'(w_acc1) + 20'(w_e_scl)) : w_acc1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            if (w_issue && !i_job.is_load) begin
                r_ch <= !w_last;
            end
            r_s1_valid  <= w_issue && !i_job.is_load;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1         <= w_meta;
            r_s2         <= r_s1;
            r_m_prod     <= w_m_prod;
            r_e_prod     <= w_e_prod;
            r_out        <= r_s2;
            r_out_sample <= w_acc2;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mixed_sample  = r_out_sample;
    assign o_channel_index = r_out.ch;
    assign o_frame_last    = r_out.last;
    assign o_music_active  = r_out.m_act;
    assign o_effect_active = r_out.e_act;

    a_second_channel_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch != 1'b0) |-> (i_job_valid && !i_job.is_load && i_job.two_ch))
        else $error("second channel issue without a stereo tick at queue head");

    a_not_last_is_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.ch == 1'b0))
        else $error("non-final sample of a frame is not channel zero");

    a_pop_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_job_valid && w_en))
        else $error("queue popped while empty or stalled");

endmodule

FILE: rtl/two_voice_sample_player_mixer.sv
`timescale 1ns / 1ps

// Two-voice PCM player: music and effect voices, each with a 32768-word sample memory,
// mixed with Q2.14 gains and saturated to 16 bits. The front end takes one request per
// cycle while the four-entry job queue has room; start, stop, pause and seek update the
// voice state right there, while load and tick requests go down the queue. The mixer
// side issues a load on its own and each output channel of a tick separately (each voice
// memory has a single read port), so a stereo tick issues twice and a mono tick once.
// A tick's samples pass through the job queue and then read, multiply and mix registers,
// and the mixer holds while a finished sample waits at the output. Memories come up
// undefined with no clearing pass; only loaded words should be played.
module two_voice_sample_player_mixer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_action,
    input  logic                i_voice_select,
    input  logic [14:0]         i_sample_index,
    input  logic signed [15:0]  i_sample_value,
    input  logic [14:0]         i_clip_frames,
    input  logic                i_pause_flag,
    input  logic [16:0]         i_seek_fraction,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_mixed_sample,
    output logic                o_channel_index,
    output logic                o_frame_last,
    output logic                o_music_active,
    output logic                o_effect_active
);

    logic [15:0]    r_music_gain;
    logic [15:0]    r_effect_gain;
    logic           r_effect_repeat;
    logic [1:0]     r_channel_count;

    logic           w_q_full;
    logic           w_push;
    tvsp_pkg::t_job w_push_job;
    logic           w_q_valid;
    tvsp_pkg::t_job w_head_job;
    logic           w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_music_gain    <= 16'd16384;
            r_effect_gain   <= 16'd16384;
            r_effect_repeat <= 1'b0;
            r_channel_count <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tvsp_pkg::REG_MUSIC_GAIN:    r_music_gain    <= i_cfg_data;
                tvsp_pkg::REG_EFFECT_GAIN:   r_effect_gain   <= i_cfg_data;
                tvsp_pkg::REG_EFFECT_REPEAT: r_effect_repeat <= i_cfg_data[0];
                tvsp_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    tvsp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_voice_select  (i_voice_select),
        .i_sample_index  (i_sample_index),
        .i_sample_value  (i_sample_value),
        .i_clip_frames   (i_clip_frames),
        .i_pause_flag    (i_pause_flag),
        .i_seek_fraction (i_seek_fraction),
        .i_effect_repeat (r_effect_repeat),
        .i_channel_count (r_channel_count),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    tvsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    tvsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_q_valid),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .i_music_gain    (r_music_gain),
        .i_effect_gain   (r_effect_gain),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mixed_sample  (o_mixed_sample),
        .o_channel_index (o_channel_index),
        .o_frame_last    (o_frame_last),
        .o_music_active  (o_music_active),
        .o_effect_active (o_effect_active)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam bit VOICE_MUSIC  = 1'b0;
    localparam bit VOICE_EFFECT = 1'b1;

    localparam int PRELOAD_WORDS   = 32;
    localparam int PLAY_FRAMES_MAX = PRELOAD_WORDS / 2;
    localparam int PHASE_ITEMS     = 230;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 2000;

    typedef struct packed {
        logic [2:0]  action;
        logic        voice;
        logic [14:0] sample_index;
        logic [15:0] sample_value;
        logic [14:0] clip_frames;
        logic        pause_flag;
        logic [16:0] seek_fraction;
    } t_mix_request;

    typedef struct {
        logic [15:0] sample;
        logic        chan;
        logic        last;
        logic        m_on;
        logic        e_on;
    } t_mix_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_mix_request cur_req = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic signed [15:0] o_mixed_sample;
    logic o_channel_index;
    logic o_frame_last;
    logic o_music_active;
    logic o_effect_active;

    // voice state tracked per accepted request, register copies tracked per register write
    bit [15:0] sample_ram [2][32768];
    bit [14:0] play_pos [2];
    bit [14:0] clip_len [2];
    bit voice_on [2];
    bit voice_held [2];
    bit [15:0] music_gain_q = 16'd16384;
    bit [15:0] effect_gain_q = 16'd16384;
    bit effect_loop = 1'b0;
    bit [1:0] chan_setting = 2'd2;

    t_mix_request pending_reqs[$];
    t_mix_out expected_mix[$];
    t_mix_out want;
    int requests_queued = 0;
    int requests_done = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int phase;
    int v_idx;
    int w_idx;

    two_voice_sample_player_mixer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (cur_req.action),
        .i_voice_select  (cur_req.voice),
        .i_sample_index  (cur_req.sample_index),
        .i_sample_value  (cur_req.sample_value),
        .i_clip_frames   (cur_req.clip_frames),
        .i_pause_flag    (cur_req.pause_flag),
        .i_seek_fraction (cur_req.seek_fraction),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mixed_sample  (o_mixed_sample),
        .o_channel_index (o_channel_index),
        .o_frame_last    (o_frame_last),
        .o_music_active  (o_music_active),
        .o_effect_active (o_effect_active)
    );

    always #5 i_clk = ~i_clk;

    function automatic int sat16(input longint v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return int'(v);
    endfunction

    // signed product over 2^14, truncated toward zero
    function automatic int scale_gain(input int s, input bit [15:0] g);
        longint p;
        p = longint'(s) * longint'(g);
        return int'(p / 16384);
    endfunction

    task automatic fetch_voice(input bit v, input bit wrap, input int chans,
                               output bit got, output int s0, output int s1);
        int unsigned base;
        logic signed [15:0] w0;
        logic signed [15:0] w1;
        got = 1'b0;
        s0 = 0;
        s1 = 0;
        if (voice_on[v] && !voice_held[v] && clip_len[v] != 0) begin
            if (play_pos[v] >= clip_len[v] && !wrap) begin
                voice_on[v] = 1'b0;
            end else begin
                if (play_pos[v] >= clip_len[v]) play_pos[v] = '0;
                base = play_pos[v] * chans;
                w0 = sample_ram[v][base[14:0]];
                w1 = sample_ram[v][15'(base + 1)];
                s0 = w0;
                s1 = w1;
                play_pos[v] = play_pos[v] + 1'b1;
                got = 1'b1;
            end
        end
    endtask

    task automatic play_request(input t_mix_request r);
        int chans;
        int c;
        int acc;
        int m0, m1, e0, e1;
        bit m_got, e_got;
        int unsigned f;
        int unsigned p;
        t_mix_out o;
        case (r.action)
            tvsp_pkg::ACT_TICK: begin
                chans = (chan_setting <= 2'd1) ? 1 : 2;
                if (chans > tvsp_pkg::MAX_CHANNELS) chans = tvsp_pkg::MAX_CHANNELS;
                fetch_voice(VOICE_MUSIC, 1'b1, chans, m_got, m0, m1);
                fetch_voice(VOICE_EFFECT, effect_loop, chans, e_got, e0, e1);
                for (c = 0; c < chans; c++) begin
                    acc = 0;
                    if (m_got)
                        acc = sat16(longint'(acc) + scale_gain(c == 0 ? m0 : m1, music_gain_q));
                    if (e_got)
                        acc = sat16(longint'(acc) + scale_gain(c == 0 ? e0 : e1, effect_gain_q));
                    o.sample = acc[15:0];
                    o.chan = c[0];
                    o.last = (c == chans - 1);
                    o.m_on = voice_on[0];
                    o.e_on = voice_on[1];
                    expected_mix.push_back(o);
                end
            end
            tvsp_pkg::ACT_LOAD: sample_ram[r.voice][r.sample_index] = r.sample_value;
            tvsp_pkg::ACT_START: begin
                f = r.clip_frames;
                if (f > tvsp_pkg::MAX_FRAMES) f = tvsp_pkg::MAX_FRAMES;
                clip_len[r.voice] = f[14:0];
                play_pos[r.voice] = '0;
                voice_held[r.voice] = 1'b0;
                voice_on[r.voice] = (f != 0);
            end
            tvsp_pkg::ACT_STOP: begin
                clip_len[r.voice] = '0;
                play_pos[r.voice] = '0;
                voice_on[r.voice] = 1'b0;
                voice_held[r.voice] = 1'b0;
            end
            tvsp_pkg::ACT_PAUSE: voice_held[r.voice] = r.pause_flag;
            tvsp_pkg::ACT_SEEK: begin
                if (voice_on[r.voice] && clip_len[r.voice] != 0) begin
                    f = r.seek_fraction;
                    if (f > 65536) f = 65536;
                    p = (f * clip_len[r.voice]) >> 16;
                    if (p >= clip_len[r.voice]) p = clip_len[r.voice] - 1;
                    play_pos[r.voice] = p[14:0];
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, exp_val));
    endtask

    // request builders: fields the action does not use carry random noise
    function automatic t_mix_request noise_request(input logic [2:0] act, input logic v);
        t_mix_request r;
        r.action = act;
        r.voice = v;
        r.sample_index = 15'($urandom);
        r.sample_value = 16'($urandom);
        r.clip_frames = 15'($urandom);
        r.pause_flag = 1'($urandom);
        r.seek_fraction = 17'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_request(input t_mix_request r);
        pending_reqs.push_back(r);
        requests_queued++;
    endtask

    task automatic queue_plain(input logic [2:0] act, input logic v);
        queue_request(noise_request(act, v));
    endtask

    task automatic queue_load(input logic v, input logic [14:0] idx, input logic [15:0] val);
        t_mix_request r;
        r = noise_request(tvsp_pkg::ACT_LOAD, v);
        r.sample_index = idx;
        r.sample_value = val;
        queue_request(r);
    endtask

    task automatic queue_start(input logic v, input logic [14:0] frames);
        t_mix_request r;
        r = noise_request(tvsp_pkg::ACT_START, v);
        r.clip_frames = frames;
        queue_request(r);
    endtask

    task automatic queue_pause(input logic v, input logic flag);
        t_mix_request r;
        r = noise_request(tvsp_pkg::ACT_PAUSE, v);
        r.pause_flag = flag;
        queue_request(r);
    endtask

    task automatic queue_seek(input logic v, input logic [16:0] frac);
        t_mix_request r;
        r = noise_request(tvsp_pkg::ACT_SEEK, v);
        r.seek_fraction = frac;
        queue_request(r);
    endtask

    // clip lengths stay within the preloaded words, so playback never reads unwritten memory
    task automatic queue_random_items(input int count);
        int pick;
        logic v;
        repeat (count) begin
            pick = $urandom_range(99);
            v = 1'($urandom);
            if (pick < 45) begin
                queue_plain(tvsp_pkg::ACT_TICK, v);
            end else if (pick < 63) begin
                queue_load(v, ($urandom_range(3) != 0) ? 15'($urandom_range(PRELOAD_WORDS - 1))
                                                       : 15'($urandom), rand_sample());
            end else if (pick < 75) begin
                queue_start(v, 15'($urandom_range(PLAY_FRAMES_MAX)));
            end else if (pick < 80) begin
                queue_plain(tvsp_pkg::ACT_STOP, v);
            end else if (pick < 87) begin
                queue_pause(v, $urandom_range(99) < 35);
            end else if (pick < 96) begin
                queue_seek(v, ($urandom_range(3) != 0) ? 17'($urandom_range(65536))
                                                       : 17'($urandom));
            end else begin
                queue_plain(pick[0] ? ACT_SPARE_6 : ACT_SPARE_7, v);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            tvsp_pkg::REG_MUSIC_GAIN:    music_gain_q = data;
            tvsp_pkg::REG_EFFECT_GAIN:   effect_gain_q = data;
            tvsp_pkg::REG_EFFECT_REPEAT: effect_loop = data[0];
            tvsp_pkg::REG_CHANNEL_COUNT: chan_setting = data[1:0];
            default: ;
        endcase
    endtask

    // upper data bits of the narrow registers get noise
    task automatic set_mix_config(input logic [15:0] mg, input logic [15:0] eg,
                                  input logic rep, input logic [1:0] cc);
        write_reg(tvsp_pkg::REG_MUSIC_GAIN, mg);
        write_reg(tvsp_pkg::REG_EFFECT_GAIN, eg);
        write_reg(tvsp_pkg::REG_EFFECT_REPEAT, {15'($urandom), rep});
        write_reg(tvsp_pkg::REG_CHANNEL_COUNT, {14'($urandom), cc});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // loads give no samples, so leave time for queued jobs after the last sample
    task automatic wait_drained();
        while (requests_done != requests_queued || expected_mix.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                play_request(cur_req);
                requests_done++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_mix.size() == 0) begin
                report_mismatch("sample with no tick pending");
            end else begin
                want = expected_mix.pop_front();
                check_field("mixed_sample", o_mixed_sample, want.sample);
                check_field("channel_index", o_channel_index, want.chan);
                check_field("frame_last", o_frame_last, want.last);
                check_field("music_active", o_music_active, want.m_on);
                check_field("effect_active", o_effect_active, want.e_on);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 34;
        recv_idle_pct <= 53;

        // both voices at full scale saturate the mix in each direction
        queue_load(VOICE_MUSIC, 15'd0, 16'h7FFF);
        queue_load(VOICE_MUSIC, 15'd1, 16'h8000);
        queue_load(VOICE_EFFECT, 15'd0, 16'h7FFF);
        queue_load(VOICE_EFFECT, 15'd1, 16'h8000);
        queue_start(VOICE_MUSIC, 15'd1);
        queue_start(VOICE_EFFECT, 15'd1);
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        // music wraps, one-shot effect runs off its end
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        // pause and seek on a stopped voice, then a clip beyond the frame limit
        queue_load(VOICE_EFFECT, 15'h7FFE, 16'h8001);
        queue_load(VOICE_EFFECT, 15'h7FFF, 16'h0001);
        queue_pause(VOICE_EFFECT, 1'b1);
        queue_seek(VOICE_EFFECT, 17'd100);
        queue_start(VOICE_EFFECT, 15'h7FFF);
        queue_seek(VOICE_EFFECT, 17'h1FFFF);
        queue_pause(VOICE_MUSIC, 1'b1);
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        queue_pause(VOICE_MUSIC, 1'b0);
        queue_seek(VOICE_MUSIC, 17'h10000);
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        queue_plain(tvsp_pkg::ACT_STOP, VOICE_MUSIC);
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        queue_plain(ACT_SPARE_6, 1'($urandom));
        queue_plain(ACT_SPARE_7, 1'($urandom));
        queue_start(VOICE_MUSIC, 15'd0);
        queue_plain(tvsp_pkg::ACT_TICK, 1'($urandom));
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct <= 34;
                recv_idle_pct <= 53;
            end else if (phase < 4) begin
                send_idle_pct <= 53;
                recv_idle_pct <= 34;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (phase)
                0: set_mix_config(16'hFFFF, 16'hFFFF, 1'b1, 2'd2);
                1: set_mix_config(16'h0000, 16'h4000, 1'b0, 2'd1);
                2: set_mix_config(16'($urandom_range(1, 16383)), 16'h0000, 1'b1, 2'd0);
                3: set_mix_config(16'($urandom), 16'($urandom), 1'b0, 2'd3);
                4: set_mix_config(16'h4000, 16'hFFFF, 1'b1, 2'd2);
                default: set_mix_config(16'($urandom), 16'($urandom), 1'($urandom),
                                        2'($urandom));
            endcase
            if (phase == 0) begin
                for (v_idx = 0; v_idx < 2; v_idx++)
                    for (w_idx = 0; w_idx < PRELOAD_WORDS; w_idx++)
                        queue_load(v_idx[0], w_idx[14:0], rand_sample());
            end
            // receiver stalls long enough for the request path to back up
            if (phase == 4) hold_req <= 1'b1;
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tvsp_pkg.sv
rtl/tvsp_front.sv
rtl/tvsp_queue.sv
rtl/tvsp_back.sv
rtl/two_voice_sample_player_mixer.sv
dv/tb.sv
